### rtl/tsg_pkg.sv
// Shared types and constants of the tile span generator.
// No dependencies; every other file imports this package.
package tsg_pkg;

  localparam int FRAG_MAX    = 32;
  localparam int MAX_TILE_W  = 64;
  localparam int MAX_TILE_H  = 16;
  localparam int MAX_RESULTS = 64;
  localparam int FRAME_LIMIT = 4096;

  localparam int IDX_W  = 24;  // tile_index
  localparam int FW_W   = 13;  // frame_width, frame_height
  localparam int TW_W   = 7;   // tile_width
  localparam int TH_W   = 5;   // tile_height
  localparam int X_W    = 12;  // span_x_first, span_row
  localparam int XE_W   = 13;  // span_x_end
  localparam int N_W    = $clog2(MAX_RESULTS);
  localparam int CNT_W  = $clog2(IDX_W);
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 13;
  localparam int PROD_W = IDX_W + TW_W;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TILE_WIDTH   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TILE_HEIGHT  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STEREO_MODE  = 3'd4;

  typedef struct packed {
    logic capture;     // register tile_index
    logic div_start;   // start the serial divider
    logic div_sel_td;  // 1: tiles down, 0: column/row split
    logic latch_td;
    logic latch_qr;
    logic mul;         // form tile origin
    logic init_span;
    logic advance;     // span transferred, step counters
  } tsg_cmd_t;

  typedef struct packed {
    logic frame_empty;
    logic div_done;
    logic beyond;
    logic span_last;
  } tsg_status_t;

endpackage

### rtl/tsg_if.sv
// Stream interfaces of the tile span generator: tile input and span output.
// Depends on tsg_pkg.
interface tsg_in_if;
  import tsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] tile_index;

  modport source (output valid, output tile_index, input ready);
  modport sink   (input valid, input tile_index, output ready);
endinterface

interface tsg_out_if;
  import tsg_pkg::*;
  logic            valid;
  logic            ready;
  logic [X_W-1:0]  span_x_first;
  logic [XE_W-1:0] span_x_end;
  logic [X_W-1:0]  span_row;
  logic            eye;
  logic            last;

  modport source (output valid, output span_x_first, output span_x_end,
                  output span_row, output eye, output last, input ready);
  modport sink   (input valid, input span_x_first, input span_x_end,
                  input span_row, input eye, input last, output ready);
endinterface

### rtl/tsg_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tsg_pkg.
module tsg_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [tsg_pkg::IDX_W-1:0] dividend_i,
  input  logic [tsg_pkg::FW_W-1:0]  divisor_i,
  output logic [tsg_pkg::IDX_W-1:0] quot_o,
  output logic [tsg_pkg::FW_W-1:0]  rem_o,
  output logic                 done_o
);
  import tsg_pkg::*;

  logic [IDX_W-1:0] dvd_q, dvd_d;
  logic [FW_W-1:0]  dvs_q, dvs_d;
  logic [FW_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [FW_W:0]    trial, diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[IDX_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(IDX_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[IDX_W-2:0], ge};
      rem_d = ge ? diff[FW_W-1:0] : trial[FW_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### rtl/tsg_datapath.sv
// Datapath: configuration registers, tile split and origin, span counters.
// Depends on tsg_pkg and tsg_divider.
module tsg_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsg_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [tsg_pkg::CDAT_W-1:0] cfg_data_i,
  input  logic [tsg_pkg::IDX_W-1:0] tile_index_i,
  input  tsg_pkg::tsg_cmd_t         cmd_i,
  output tsg_pkg::tsg_status_t      status_o,
  output logic [tsg_pkg::X_W-1:0]   span_x_first_o,
  output logic [tsg_pkg::XE_W-1:0]  span_x_end_o,
  output logic [tsg_pkg::X_W-1:0]   span_row_o,
  output logic                      eye_o,
  output logic                      last_o
);
  import tsg_pkg::*;

  logic [FW_W-1:0] fw_cfg_q, fh_cfg_q;
  logic [TW_W-1:0] tw_cfg_q;
  logic [TH_W-1:0] th_cfg_q;
  logic            stereo_q;

  logic [FW_W-1:0] fw_eff, fh_eff;
  logic [TW_W-1:0] tw_eff;
  logic [TH_W-1:0] th_eff;

  logic [IDX_W-1:0]  idx_q, col_q;
  logic [FW_W-1:0]   td_q;
  logic [X_W-1:0]    row_q;
  logic [PROD_W-1:0] x0_q;
  logic [X_W-1:0]    y0_q;
  logic [XE_W-1:0]   x1_q, y1_q;
  logic [X_W-1:0]    x_q, y_q;
  logic              eye_q;
  logic [N_W-1:0]    n_q;

  logic [FW_W:0]         td_num;
  logic [IDX_W-1:0]      div_dividend, div_quot;
  logic [FW_W-1:0]       div_divisor, div_rem;
  logic                  div_done;
  logic [PROD_W-1:0]     x0_full;
  logic [X_W+TH_W-1:0]   y0_full;
  logic [XE_W-1:0]       x1_full, y1_full, xe_full, y_next;
  logic                  x_wrap, y_wrap;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_cfg_q <= FW_W'(640);
      fh_cfg_q <= FW_W'(480);
      tw_cfg_q <= TW_W'(32);
      th_cfg_q <= TH_W'(2);
      stereo_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_cfg_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_cfg_q <= cfg_data_i[FW_W-1:0];
        CFG_TILE_WIDTH:   tw_cfg_q <= cfg_data_i[TW_W-1:0];
        CFG_TILE_HEIGHT:  th_cfg_q <= cfg_data_i[TH_W-1:0];
        CFG_STEREO_MODE:  stereo_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_eff = (fw_cfg_q > FW_W'(FRAME_LIMIT)) ? FW_W'(FRAME_LIMIT) : fw_cfg_q;
    fh_eff = (fh_cfg_q > FW_W'(FRAME_LIMIT)) ? FW_W'(FRAME_LIMIT) : fh_cfg_q;
    if (tw_cfg_q == '0)                   tw_eff = TW_W'(1);
    else if (tw_cfg_q > TW_W'(MAX_TILE_W)) tw_eff = TW_W'(MAX_TILE_W);
    else                                  tw_eff = tw_cfg_q;
    if (th_cfg_q == '0)                   th_eff = TH_W'(1);
    else if (th_cfg_q > TH_W'(MAX_TILE_H)) th_eff = TH_W'(MAX_TILE_H);
    else                                  th_eff = th_cfg_q;
  end

  // First pass: tiles down = ceil(fh / th); second pass: index / tiles down
  assign td_num       = {1'b0, fh_eff} + (FW_W+1)'(th_eff) - (FW_W+1)'(1);
  assign div_dividend = cmd_i.div_sel_td ? IDX_W'(td_num) : idx_q;
  assign div_divisor  = cmd_i.div_sel_td ? FW_W'(th_eff) : td_q;

  tsg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  assign x0_full = PROD_W'(col_q) * PROD_W'(tw_eff);
  assign y0_full = (X_W+TH_W)'(row_q) * (X_W+TH_W)'(th_eff);

  assign x1_full = XE_W'(x0_q[X_W-1:0]) + XE_W'(tw_eff);
  assign y1_full = XE_W'(y0_q) + XE_W'(th_eff);

  assign xe_full = XE_W'(x_q) + XE_W'(FRAG_MAX);
  assign y_next  = XE_W'(y_q) + XE_W'(1);
  assign x_wrap  = xe_full >= x1_q;
  assign y_wrap  = y_next >= y1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)  idx_q <= tile_index_i;
    if (cmd_i.latch_td) td_q  <= div_quot[FW_W-1:0];
    if (cmd_i.latch_qr) begin
      col_q <= div_quot;
      row_q <= div_rem[X_W-1:0];
    end
    if (cmd_i.mul) begin
      x0_q <= x0_full;
      y0_q <= y0_full[X_W-1:0];
    end
    if (cmd_i.init_span) begin
      x1_q  <= (x1_full > fw_eff) ? fw_eff : x1_full;
      y1_q  <= (y1_full > fh_eff) ? fh_eff : y1_full;
      x_q   <= x0_q[X_W-1:0];
      y_q   <= y0_q;
      eye_q <= 1'b0;
      n_q   <= '0;
    end else if (cmd_i.advance) begin
      n_q <= n_q + N_W'(1);
      if (!x_wrap) begin
        x_q <= xe_full[X_W-1:0];
      end else begin
        x_q <= x0_q[X_W-1:0];
        if (!y_wrap) begin
          y_q <= y_next[X_W-1:0];
        end else begin
          y_q   <= y0_q;
          eye_q <= 1'b1;
        end
      end
    end
  end

  assign last_o = (n_q == N_W'(MAX_RESULTS - 1)) ||
                  (x_wrap && y_wrap && (eye_q || !stereo_q));

  assign span_x_first_o = x_q;
  assign span_x_end_o   = x_wrap ? x1_q : xe_full;
  assign span_row_o     = y_q;
  assign eye_o          = eye_q;

  assign status_o.frame_empty = (fw_eff == '0) || (fh_eff == '0);
  assign status_o.div_done    = div_done;
  assign status_o.beyond      = x0_q >= PROD_W'(fw_eff);
  assign status_o.span_last   = last_o;

endmodule

### rtl/tsg_ctrl.sv
// Controller state machine: sequences the divisions, origin and span run.
// Depends on tsg_pkg.
module tsg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tsg_pkg::tsg_status_t status_i,
  output tsg_pkg::tsg_cmd_t    cmd_o
);
  import tsg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_DIV_TD    = 7'b0000010,
    ST_COL_START = 7'b0000100,
    ST_DIV_COL   = 7'b0001000,
    ST_MUL       = 7'b0010000,
    ST_CHECK     = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } tsg_state_e;

  tsg_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!status_i.frame_empty) begin
            cmd_o.div_start  = 1'b1;
            cmd_o.div_sel_td = 1'b1;
            state_d          = ST_DIV_TD;
          end
        end
      end
      ST_DIV_TD: begin
        if (status_i.div_done) begin
          cmd_o.latch_td = 1'b1;
          state_d        = ST_COL_START;
        end
      end
      ST_COL_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_COL;
      end
      ST_DIV_COL: begin
        if (status_i.div_done) begin
          cmd_o.latch_qr = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.beyond) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.init_span = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (status_i.span_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/tile_span_generator_core.sv
// Tile span generator top level: controller plus datapath on stream channels.
// Depends on tsg_pkg, tsg_if, tsg_ctrl, tsg_datapath.
//
// Each accepted tile_index is split column major into a tile column and row
// (tiles down = ceil(frame_height / tile_height)), clamped to the frame, and
// emitted as spans of up to 32 pixels, row by row, repeated for eye 1 in
// stereo mode; the final span carries last. One tile is in flight at a time.
// Setup runs from the input transfer to the first span: two passes of the
// 24-step serial divider (tiles down, then column/row split), plus origin
// multiply and bound check. Spans then leave at one per cycle while the
// output is ready, up to 64 per tile, and the next tile is taken the cycle
// after the last span's transfer. Tiles beyond the frame produce no spans
// after the divisions, multiply and check; a zero-size frame produces none and skips setup.
module tile_span_generator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tsg_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [tsg_pkg::CDAT_W-1:0] cfg_data_i,
  tsg_in_if.sink                     tile_in,
  tsg_out_if.source                  span_out
);
  import tsg_pkg::*;

  tsg_cmd_t    cmd;
  tsg_status_t status;

  tsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tile_in.valid),
    .in_ready_o  (tile_in.ready),
    .out_valid_o (span_out.valid),
    .out_ready_i (span_out.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsg_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .tile_index_i   (tile_in.tile_index),
    .cmd_i          (cmd),
    .status_o       (status),
    .span_x_first_o (span_out.span_x_first),
    .span_x_end_o   (span_out.span_x_end),
    .span_row_o     (span_out.span_row),
    .eye_o          (span_out.eye),
    .last_o         (span_out.last)
  );

  // Spans are never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_out.valid |-> (XE_W'(span_out.span_x_first) < span_out.span_x_end))
    else $error("empty span emitted");

  // No new tile while spans are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_out.valid |-> !tile_in.ready)
    else $error("tile accepted during span run");

  // Run ends with the last transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_out.valid && span_out.ready && span_out.last) |=> !span_out.valid)
    else $error("span emitted after last");

  // Within each eye's pass of a tile, rows never decrease
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_out.valid && span_out.ready && !span_out.last) |=>
      (span_out.valid && span_out.span_row >= $past(span_out.span_row)) ||
      (span_out.valid && span_out.eye && !$past(span_out.eye)))
    else $error("span row order broken");

endmodule
